[src/uud_pkg.sv]
// Shared types, character constants and hex helpers for the URL percent decoder.
package uud_pkg;

   localparam int MaxResults = 3;
   localparam int CapWidth   = 16;
   localparam int CsrWidth   = 32;
   localparam int AddrWidth  = 3;

   localparam logic [7:0] ChNul     = 8'h00;
   localparam logic [7:0] ChPercent = 8'h25;
   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;
   localparam logic [7:0] ChUpperA  = 8'h41;
   localparam logic [7:0] ChUpperF  = 8'h46;
   localparam logic [7:0] ChLowerA  = 8'h61;
   localparam logic [7:0] ChLowerF  = 8'h66;

   localparam logic [CapWidth-1:0] CapacityReset = 16'd256;
   localparam logic [0:0]          RegOutCapacity = 1'b0;

   typedef enum logic [1:0] {
      PhIdle    = 2'd0,
      PhPercent = 2'd1,
      PhDigit   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_end;
   } entry_type;

   typedef struct packed {
      logic [1:0]                     count;
      entry_type [MaxResults-1:0]     ents;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c inside {[ChZero:ChNine], [ChUpperA:ChUpperF], [ChLowerA:ChLowerF]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[ChZero:ChNine]}) begin
         v = c - ChZero;
      end else if (c inside {[ChUpperA:ChUpperF]}) begin
         v = c - ChUpperA + 8'd10;
      end else begin
         v = c - ChLowerA + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

[src/url_percent_decoder.sv]
// Top level of the streaming URL percent decoder with its register port.
//
// Decodes a form-urlencoded string one byte per input word: '%' with two hex
// digits becomes one byte, '+' becomes a space, a byte of 0 ends the string
// and yields a terminator word with rsp_is_end high, after which the escape
// state and the data count are cleared for the next string. A broken escape
// is flushed literally before the breaking byte is handled afresh. At most
// out_capacity minus one data words are delivered per string; the rest are
// dropped quietly, but the terminator always comes. The front end accepts
// one word per cycle whenever its two-entry command queue has room; the back
// end delivers one result word per cycle while rsp_ready does not stall it,
// and an input word that yields two or three results (a broken escape)
// holds the back end until all of them are handled. Dropped data bytes also
// occupy the back end. An accepted word's first result passes through the
// command queue and then the output register. The only register,
// out_capacity, sits at byte address 0 and resets to 256; it should be
// written only while the decoder is idle.
module url_percent_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_is_end,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [uud_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [uud_pkg::CsrWidth-1:0]    csr_pwdata,
   output logic [uud_pkg::CsrWidth-1:0]    csr_prdata,
   output logic                            csr_pready
);

   logic [uud_pkg::CapWidth-1:0] capacity_ff, capacity_in;
   logic                         reg_hit;
   logic                         push, pop;
   uud_pkg::cmd_type             push_cmd, head;
   uud_pkg::fifo_status_type     fifo_status;

   // Register port: the word index is the address divided by four.
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == uud_pkg::RegOutCapacity);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         capacity_in = csr_pwdata[uud_pkg::CapWidth-1:0];
      end
   end

   assign csr_prdata = reg_hit
      ? {{(uud_pkg::CsrWidth-uud_pkg::CapWidth){1'b0}}, capacity_ff}
      : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= uud_pkg::CapacityReset;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // The front end classifies each word and queues the results it implies.
   uud_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .fifo_status (fifo_status),
      .push        (push),
      .cmd         (push_cmd)
   );

   uud_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (fifo_status)
   );

   // The back end owns the capacity count and the output register.
   uud_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .fifo_status  (fifo_status),
      .out_capacity (capacity_ff),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_end   (rsp_is_end)
   );

endmodule

[src/uud_front.sv]
// Front end: accepts input words, tracks escape state and builds result commands.
module uud_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_in_byte,
   input  uud_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output uud_pkg::cmd_type         cmd
);

   uud_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;
   logic               accept;

   assign req_ready = !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (cmd.count != 2'd0);

   // Next escape state.
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (accept) begin
         if (phase_ff == uud_pkg::PhPercent && uud_pkg::is_hex(req_in_byte)) begin
            phase_in = uud_pkg::PhDigit;
            held_in  = req_in_byte;
         end else if (phase_ff == uud_pkg::PhDigit && uud_pkg::is_hex(req_in_byte)) begin
            phase_in = uud_pkg::PhIdle;
         end else if (req_in_byte == uud_pkg::ChPercent) begin
            phase_in = uud_pkg::PhPercent;
         end else begin
            phase_in = uud_pkg::PhIdle;
         end
      end
   end

   // Result command for the current word.
   always_comb begin
      logic [1:0] n;
      logic       fresh;
      n     = 2'd0;
      fresh = 1'b0;
      cmd   = '0;
      case (phase_ff)
         uud_pkg::PhPercent: begin
            if (!uud_pkg::is_hex(req_in_byte)) begin
               cmd.ents[n] = '{data: uud_pkg::ChPercent, is_end: 1'b0};
               n           = n + 2'd1;
               fresh       = 1'b1;
            end
         end
         uud_pkg::PhDigit: begin
            if (uud_pkg::is_hex(req_in_byte)) begin
               cmd.ents[n] = '{data: {uud_pkg::hex_value(held_ff),
                                      uud_pkg::hex_value(req_in_byte)}, is_end: 1'b0};
               n           = n + 2'd1;
            end else begin
               cmd.ents[n] = '{data: uud_pkg::ChPercent, is_end: 1'b0};
               n           = n + 2'd1;
               cmd.ents[n] = '{data: held_ff, is_end: 1'b0};
               n           = n + 2'd1;
               fresh       = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase
      if (fresh) begin
         if (req_in_byte == uud_pkg::ChNul) begin
            cmd.ents[n] = '{data: uud_pkg::ChNul, is_end: 1'b1};
            n           = n + 2'd1;
         end else if (req_in_byte == uud_pkg::ChPlus) begin
            cmd.ents[n] = '{data: uud_pkg::ChSpace, is_end: 1'b0};
            n           = n + 2'd1;
         end else if (req_in_byte != uud_pkg::ChPercent) begin
            cmd.ents[n] = '{data: req_in_byte, is_end: 1'b0};
            n           = n + 2'd1;
         end
      end
      cmd.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uud_pkg::PhIdle;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("command pushed into a full queue");

   // The digit phase is entered from a pending percent and may then wait for input.
   a_digit_after_percent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == uud_pkg::PhDigit) |-> ($past(phase_ff) != uud_pkg::PhIdle))
      else $error("digit phase entered without a pending percent");

endmodule

[src/uud_cmd_fifo.sv]
// Two-entry queue of result commands between the front and back ends.
module uud_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  uud_pkg::cmd_type         push_cmd,
   input  logic                     pop,
   output uud_pkg::cmd_type         head,
   output uud_pkg::fifo_status_type status
);

   uud_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty queue");

endmodule

[src/uud_back.sv]
// Back end: walks each command, applies the capacity limit and drives the output register.
module uud_back (
   input  logic                            clock,
   input  logic                            reset,
   input  uud_pkg::cmd_type                head,
   input  uud_pkg::fifo_status_type        fifo_status,
   input  logic [uud_pkg::CapWidth-1:0]    out_capacity,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_is_end
);

   logic [1:0]                   idx_ff, idx_in;
   logic [uud_pkg::CapWidth-1:0] emitted_ff, emitted_in;
   logic                         valid_ff, valid_in;
   logic [7:0]                   byte_ff;
   logic                         end_ff;
   logic [uud_pkg::CapWidth-1:0] limit;
   uud_pkg::entry_type           ent;
   logic                         step, emit, last;

   assign limit = (out_capacity == '0) ? '0 : out_capacity - 1'b1;
   assign ent   = head.ents[idx_ff];
   assign step  = !fifo_status.empty && (!valid_ff || rsp_ready);
   assign emit  = step && (ent.is_end || (emitted_ff < limit));
   assign last  = (idx_ff == head.count - 2'd1);
   assign pop   = step && last;

   always_comb begin
      idx_in     = idx_ff;
      emitted_in = emitted_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (step) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
      if (emit) begin
         valid_in   = 1'b1;
         emitted_in = ent.is_end ? '0 : emitted_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= ent.data;
         end_ff  <= ent.is_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 2'd0;
         emitted_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         emitted_ff <= emitted_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_end   = end_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !fifo_status.empty |-> (idx_ff < head.count))
      else $error("slot index beyond the command length");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit && ent.is_end) |=> (emitted_ff == '0))
      else $error("emitted count not cleared after a terminator");

endmodule
